[rtl/keyboard_line_input_fifo_macros.svh]
// ----------------------------------------------------------------------------
// keyboard_line_input_fifo_macros.svh
// Assertion helpers used by the keyboard FIFO checker.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_LINE_INPUT_FIFO_MACROS_SVH
`define KEYBOARD_LINE_INPUT_FIFO_MACROS_SVH

// Same-cycle implication, masked during reset.
`define KLIF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define KLIF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define KLIF_ASSERT_NXT_RAW(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/klif_pkg.sv]
// ----------------------------------------------------------------------------
// klif_pkg
// Opcodes, character constants, result type and scan code table.
// ----------------------------------------------------------------------------
package klif_pkg;

  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [7:0] SCAN_ENTER     = 8'h1C;
  localparam logic [7:0] SCAN_BACKSPACE = 8'h0E;
  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE   = 8'h08;

  localparam int FILL_W = 9;

  typedef struct packed {
    logic              echo_valid;
    logic [7:0]        echo_char;
    logic              read_valid;
    logic [7:0]        read_char;
    logic              char_dropped;
    logic              buffer_empty;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  // Set-1 make code to ASCII; zero means no character.
  function automatic logic [7:0] xlat_code(input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    case (code)
      8'h02: ch = 8'h31; // 1
      8'h03: ch = 8'h32;
      8'h04: ch = 8'h33;
      8'h05: ch = 8'h34;
      8'h06: ch = 8'h35;
      8'h07: ch = 8'h36;
      8'h08: ch = 8'h37;
      8'h09: ch = 8'h38;
      8'h0A: ch = 8'h39;
      8'h0B: ch = 8'h30; // 0
      8'h0C: ch = 8'h2D; // -
      8'h0D: ch = 8'h3D; // =
      8'h10: ch = 8'h71; // q
      8'h11: ch = 8'h77;
      8'h12: ch = 8'h65;
      8'h13: ch = 8'h72;
      8'h14: ch = 8'h74;
      8'h15: ch = 8'h79;
      8'h16: ch = 8'h75;
      8'h17: ch = 8'h69;
      8'h18: ch = 8'h6F;
      8'h19: ch = 8'h70; // p
      8'h1A: ch = 8'h5B; // [
      8'h1B: ch = 8'h5D; // ]
      8'h1E: ch = 8'h61; // a
      8'h1F: ch = 8'h73;
      8'h20: ch = 8'h64;
      8'h21: ch = 8'h66;
      8'h22: ch = 8'h67;
      8'h23: ch = 8'h68;
      8'h24: ch = 8'h6A;
      8'h25: ch = 8'h6B;
      8'h26: ch = 8'h6C; // l
      8'h27: ch = 8'h3B; // ;
      8'h28: ch = 8'h27; // quote
      8'h29: ch = 8'h60; // backtick
      8'h2B: ch = 8'h5C; // backslash
      8'h2C: ch = 8'h7A; // z
      8'h2D: ch = 8'h78;
      8'h2E: ch = 8'h63;
      8'h2F: ch = 8'h76;
      8'h30: ch = 8'h62;
      8'h31: ch = 8'h6E;
      8'h32: ch = 8'h6D; // m
      8'h33: ch = 8'h2C; // ,
      8'h34: ch = 8'h2E; // .
      8'h35: ch = 8'h2F; // /
      8'h39: ch = 8'h20; // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[rtl/klif_if.sv]
// ----------------------------------------------------------------------------
// klif_in_if / klif_out_if
// Valid/ready channels for key requests and their results.
// ----------------------------------------------------------------------------
interface klif_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key_code;

  modport source(output valid, op, key_code, input ready);
  modport sink(input valid, op, key_code, output ready);
endinterface

interface klif_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic       read_valid;
  logic [7:0] read_char;
  logic       char_dropped;
  logic       buffer_empty;
  logic [8:0] fill_count;

  modport source(output valid, echo_valid, echo_char, read_valid, read_char,
                 char_dropped, buffer_empty, fill_count, input ready);
  modport sink(input valid, echo_valid, echo_char, read_valid, read_char,
               char_dropped, buffer_empty, fill_count, output ready);
endinterface

[rtl/klif_ram.sv]
// ----------------------------------------------------------------------------
// klif_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module klif_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/keyboard_line_input_fifo.sv]
// ----------------------------------------------------------------------------
// keyboard_line_input_fifo
// Keyboard ring buffer with scan code translation and echo.
// ----------------------------------------------------------------------------
// Use:
//   in_req  : one request per handshake; op selects key event, read or flush,
//             key_code carries the set-1 scan code for key events.
//   out_rsp : exactly one result per request, in request order: echo, popped
//             byte, drop flag, empty flag and fill count after the request.
// Path: an accepted request is registered in the request stage, then moves
//   to the output register, which drives out_rsp. The byte store read
//   happens in the first stage.
// Throughput: one request per cycle while out_rsp drains. Pointers and the
//   count live in flops, so back-to-back push/read/backspace never wait on
//   the store.
// Reset: pointers and count go to zero, both stages empty; the store is not
//   cleared since an entry is only ever read after it is written.
// Receiver stall: the output register holds its result, the request stage
//   holds one more, and in_req.ready drops once both are occupied.
// ----------------------------------------------------------------------------
module keyboard_line_input_fifo #(
  parameter int FIFO_DEPTH = 256
) (
  input logic         clk,
  input logic         rst_n,
  klif_in_if.sink     in_req,
  klif_out_if.source  out_rsp
);

  import klif_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // ring pointers and occupancy
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // request stage (store read in flight) and output register
  logic p1_valid_r;
  res_t p1_r;
  logic out_valid_r;
  res_t out_r;
  res_t out_nxt;

  logic       in_ready;
  logic       accept;
  logic       out_free;
  logic [7:0] xl;
  logic [7:0] push_char;
  logic       is_enter;
  logic       is_bksp;
  logic       has_data;
  logic       full;
  logic       wr_en;
  logic       rd_en;
  logic [7:0] rd_data;
  logic [PTR_W-1:0] wp_inc, wp_dec, rp_inc;
  res_t       res_nxt;

  assign out_free = !out_valid_r || out_rsp.ready;
  assign in_ready = !p1_valid_r || out_free;
  assign accept   = in_req.valid && in_ready;
  assign in_req.ready = in_ready;

  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign wp_dec = (wp_r == '0) ? PTR_LAST : wp_r - 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;

  // Request decode and pointer update, all in the accept cycle.
  always_comb begin
    xl        = xlat_code(in_req.key_code);
    is_enter  = (in_req.key_code == SCAN_ENTER);
    is_bksp   = (in_req.key_code == SCAN_BACKSPACE);
    push_char = is_enter ? CH_NEWLINE : xl;
    has_data  = (cnt_r != '0);
    full      = (cnt_r == CNT_FULL);
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    res_nxt   = '0;
    if (accept) begin
      case (in_req.op)
        OP_KEY: begin
          if (xl != 8'h00 || is_enter) begin
            // echo goes out even when the push is refused
            res_nxt.echo_valid = 1'b1;
            res_nxt.echo_char  = push_char;
            if (full) begin
              res_nxt.char_dropped = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wp_nxt  = wp_inc;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (is_bksp && has_data) begin
            // take back the newest unread byte
            wp_nxt             = wp_dec;
            cnt_nxt            = cnt_r - 1'b1;
            res_nxt.echo_valid = 1'b1;
            res_nxt.echo_char  = CH_BACKSPACE;
          end
        end
        OP_READ: begin
          if (has_data) begin
            rd_en              = 1'b1;
            rp_nxt             = rp_inc;
            cnt_nxt            = cnt_r - 1'b1;
            res_nxt.read_valid = 1'b1;
          end
        end
        OP_FLUSH: begin
          wp_nxt  = '0;
          rp_nxt  = '0;
          cnt_nxt = '0;
        end
        default: ;
      endcase
    end
    res_nxt.buffer_empty = (cnt_nxt == '0);
    res_nxt.fill_count   = FILL_W'(cnt_nxt);
  end

  klif_ram #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (push_char),
    .rd_en   (rd_en),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      if (in_ready) begin
        p1_valid_r <= accept;
      end
      if (out_free) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  // store data joins the staged result here
  always_comb begin
    out_nxt           = p1_r;
    out_nxt.read_char = p1_r.read_valid ? rd_data : 8'h00;
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r <= res_nxt;
    end
    if (out_free && p1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.echo_valid   = out_r.echo_valid;
  assign out_rsp.echo_char    = out_r.echo_char;
  assign out_rsp.read_valid   = out_r.read_valid;
  assign out_rsp.read_char    = out_r.read_char;
  assign out_rsp.char_dropped = out_r.char_dropped;
  assign out_rsp.buffer_empty = out_r.buffer_empty;
  assign out_rsp.fill_count   = out_r.fill_count;

endmodule

[rtl/klif_checker.sv]
// ----------------------------------------------------------------------------
// klif_checker
// Port-level checks on the keyboard FIFO results, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyboard_line_input_fifo_macros.svh"

module klif_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       echo_valid,
  input logic [7:0] echo_char,
  input logic       read_valid,
  input logic [7:0] read_char,
  input logic       char_dropped,
  input logic       buffer_empty,
  input logic [8:0] fill_count
);

  `KLIF_ASSERT_NXT_RAW(a_reset_clears_out, clk, !rst_n, !out_valid, "result valid after reset")

  `KLIF_ASSERT_NXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(echo_char) && $stable(read_char) && $stable(fill_count), "stalled result changed")

  `KLIF_ASSERT_IMP(a_empty_count, clk, rst_n, out_valid && buffer_empty, fill_count == 9'd0, "empty with nonzero fill count")

  `KLIF_ASSERT_IMP(a_read_exclusive, clk, rst_n, out_valid && read_valid, !echo_valid && !char_dropped && !buffer_empty || !echo_valid && !char_dropped, "read result also flags a key event")

  `KLIF_ASSERT_IMP(a_idle_chars_zero, clk, rst_n, out_valid && !read_valid && !echo_valid, read_char == 8'h00 && echo_char == 8'h00, "idle char fields not zero")

endmodule

bind keyboard_line_input_fifo klif_checker u_klif_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .echo_valid   (out_rsp.echo_valid),
  .echo_char    (out_rsp.echo_char),
  .read_valid   (out_rsp.read_valid),
  .read_char    (out_rsp.read_char),
  .char_dropped (out_rsp.char_dropped),
  .buffer_empty (out_rsp.buffer_empty),
  .fill_count   (out_rsp.fill_count)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyboard_line_input_fifo.
// Drives key, read, flush and unused-op requests with random gaps and result
// stalls. A shadow copy of the ring buffer predicts every result, and each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import klif_pkg::*;

  localparam int DEPTH       = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 10;       // > two-stage latency of the block
  localparam int MAX_IDLE    = 18;
  localparam int XLAT_CODES  = 60;

  // Op code 3 is unused: the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  klif_in_if  in_req();
  klif_out_if out_rsp();

  keyboard_line_input_fifo #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #1 clk = ~clk;

  // Set-1 make code -> ASCII, zero where the key has no character.
  logic [7:0] scan_ascii [XLAT_CODES] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00
  };

  // Shadow ring buffer.
  logic [7:0] shadow_store [DEPTH];
  int         shadow_wr;
  int         shadow_rd;
  int         shadow_fill;

  res_t pending_results[$];
  int   mismatches  = 0;
  int   cycle_count = 0;

  // Idle switches per side; cleared for stretches of full-rate traffic.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold_until = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Returns 1 when the byte is refused because the ring is full.
  function automatic bit shadow_push(input logic [7:0] ch);
    if (shadow_fill >= DEPTH) return 1'b1;
    shadow_store[shadow_wr] = ch;
    shadow_wr = (shadow_wr + 1) % DEPTH;
    shadow_fill++;
    return 1'b0;
  endfunction

  function automatic res_t predict_key_fifo(input logic [1:0] op, input logic [7:0] code);
    res_t       r;
    logic [7:0] ch;
    r = '0;
    case (op)
      OP_KEY: begin
        ch = (code < XLAT_CODES) ? scan_ascii[code] : 8'h00;
        if (ch != 8'h00) begin
          // Echo happens even when the push is dropped.
          r.char_dropped = shadow_push(ch);
          r.echo_valid   = 1'b1;
          r.echo_char    = ch;
        end
        if (code == SCAN_ENTER) begin
          r.char_dropped = shadow_push(CH_NEWLINE);
          r.echo_valid   = 1'b1;
          r.echo_char    = CH_NEWLINE;
        end else if (code == SCAN_BACKSPACE && shadow_fill > 0) begin
          // Take back the newest byte; pointer wraps below zero.
          shadow_wr  = (shadow_wr + DEPTH - 1) % DEPTH;
          shadow_fill--;
          r.echo_valid = 1'b1;
          r.echo_char  = CH_BACKSPACE;
        end
      end
      OP_READ: begin
        if (shadow_fill > 0) begin
          r.read_valid = 1'b1;
          r.read_char  = shadow_store[shadow_rd];
          shadow_rd    = (shadow_rd + 1) % DEPTH;
          shadow_fill--;
        end
      end
      OP_FLUSH: begin
        shadow_wr   = 0;
        shadow_rd   = 0;
        shadow_fill = 0;
      end
      default: ;  // unused op: state untouched
    endcase
    r.buffer_empty = (shadow_fill == 0);
    r.fill_count   = shadow_fill[FILL_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Drive one request at the falling edge and hold it until accepted. The
  // prediction is made on the accepting edge so it sees the same order as
  // the block.
  task automatic send_request(input logic [1:0] op, input logic [7:0] code);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.op       <= op;
    in_req.key_code <= code;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pending_results.push_back(predict_key_fifo(op, code));
  endtask

  task automatic send_key(input logic [7:0] code);
    send_request(OP_KEY, code);
  endtask

  // key_code is don't-care on reads; fill it with noise.
  task automatic send_read();
    send_request(OP_READ, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid first so the last request is not taken again while waiting.
  task automatic wait_drained();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A code that translates to a printable character.
  function automatic logic [7:0] rand_char_code();
    logic [7:0] code;
    code = 8'($urandom_range(0, XLAT_CODES - 1));
    while (scan_ascii[code] == 8'h00) code = 8'($urandom_range(0, XLAT_CODES - 1));
    return code;
  endfunction

  // Mostly printable keys, with enter, backspace and raw noise mixed in.
  function automatic logic [7:0] rand_scan();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return rand_char_code();
    if (pick < 72) return SCAN_ENTER;
    if (pick < 84) return SCAN_BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // ready changes at the falling edge; the stall length is drawn per result.
  always @(negedge clk) begin
    out_rsp.ready <= (cycle_count >= rx_hold_until);
  end

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      rx_hold_until = cycle_count + (rx_idle ? int'($urandom_range(0, MAX_IDLE)) : 0);
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("echo_valid",   want.echo_valid,   out_rsp.echo_valid);
        check_field("echo_char",    want.echo_char,    out_rsp.echo_char);
        check_field("read_valid",   want.read_valid,   out_rsp.read_valid);
        check_field("read_char",    want.read_char,    out_rsp.read_char);
        check_field("char_dropped", want.char_dropped, out_rsp.char_dropped);
        check_field("buffer_empty", want.buffer_empty, out_rsp.buffer_empty);
        check_field("fill_count",   want.fill_count,   out_rsp.fill_count);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Read, backspace, unused op and flush on an empty ring right after reset.
  task automatic test_empty_ring();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_read();
    send_key(SCAN_BACKSPACE);            // nothing to take back, no echo
    send_request(OP_UNUSED, 8'hFF);
    send_request(OP_FLUSH, 8'h55);
  endtask

  // Table edges, untranslated codes, enter and backspace, then read-out.
  task automatic test_key_codes();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    send_key(8'h00);                     // table entry 0
    send_key(8'h02);                     // '1', first printable
    send_key(8'h0D);
    send_key(8'h10);
    send_key(SCAN_ENTER);
    send_key(8'h2B);
    send_key(8'h39);                     // space, last printable
    send_key(8'h3B);                     // in range, no char
    send_key(8'h3C);                     // first code past the table
    send_key(8'h7F);
    send_key(8'h80);
    send_key(8'hFF);
    send_key(SCAN_BACKSPACE);            // drops the space
    send_request(OP_UNUSED, 8'hAA);      // must not disturb a loaded ring
    send_request(OP_READ, 8'h00);
    send_request(OP_READ, 8'hFF);
    repeat (4) send_read();              // last one finds the ring empty
  endtask

  // Wrap of both pointers, backspace at write pointer zero, drops when full.
  task automatic test_full_and_wrap();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(OP_FLUSH, 8'h00);
    repeat (5) send_key(rand_char_code());
    repeat (5) send_read();
    repeat (DEPTH - 5) send_key(rand_char_code());   // write pointer back to 0
    send_key(SCAN_BACKSPACE);                        // wraps to DEPTH-1
    repeat (6) send_key(rand_char_code());           // now full
    send_key(rand_char_code());                      // dropped, still echoed
    send_key(SCAN_ENTER);                            // newline dropped too
    send_key(SCAN_BACKSPACE);
    send_key(SCAN_ENTER);                            // full again, ends in newline
    rx_idle = 1'b1;
    repeat (DEPTH + 1) send_read();                  // read pointer wraps
  endtask

  // Sender holds off until every result is back, then resumes.
  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (10) send_key(rand_scan());
    wait_drained();
    repeat (3) send_key(rand_char_code());
    repeat (4) send_read();
    send_request(OP_FLUSH, 8'($urandom_range(0, 255)));
    send_read();
  endtask

  // Bursts with a bias toward filling, draining or a mix of both.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int flavor;
    int key_share;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      flavor    = $urandom_range(0, 2);
      key_share = (flavor == 0) ? 85 : (flavor == 1) ? 25 : 55;
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      repeat (25) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)
          send_request(OP_FLUSH, 8'($urandom_range(0, 255)));
        else if (pick < 4)
          send_request(OP_UNUSED, 8'($urandom_range(0, 255)));
        else if (pick < 4 + key_share)
          send_key(rand_scan());
        else
          send_read();
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.op       = OP_KEY;
    in_req.key_code = 8'h00;
    shadow_wr       = 0;
    shadow_rd       = 0;
    shadow_fill     = 0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_key_codes();
    test_full_and_wrap();
    test_drain_pause();
    test_random_traffic(175);

    @(negedge clk);
    in_req.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
